>>> sv/ida_pkg.sv
// shared types, codes and defaults for the id slot allocator
package ida_pkg;

    // default sizes
    localparam int CAPACITY_DEF    = 1024;
    localparam int FREE_DEPTH_DEF  = 128;
    localparam int HANDLE_BITS_DEF = 32;

    // field widths of the request and result items
    localparam int FUNC_W         = 2;
    localparam int ID_FIELD_W     = 10;
    localparam int HANDLE_FIELD_W = 32;
    localparam int STATUS_W       = 2;
    localparam int CNT_FIELD_W    = 11;
    localparam int CFG_W          = 8;

    // bitmap word size ceiling
    localparam int WORD_BITS_MAX = 32;

    // max_free_ids after reset
    localparam logic [CFG_W-1:0] DEFAULT_MAX_FREE = 8'd100;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [ID_FIELD_W-1:0]     slot_id;
        logic [HANDLE_FIELD_W-1:0] object_handle;
    } ida_req_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0]     result_id;
        logic [HANDLE_FIELD_W-1:0] result_handle;
        logic                      found;
        logic [STATUS_W-1:0]       status;
        logic [CNT_FIELD_W-1:0]    occupied_count;
    } ida_rsp_t;

    // controller state
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ida_state_t;

    // how the current request is carried out
    typedef enum logic [2:0] {
        MODE_FREE,
        MODE_EMPTY,
        MODE_APPEND,
        MODE_FULL,
        MODE_REMOVE,
        MODE_FIND,
        MODE_RANGE,
        MODE_NOP
    } ida_mode_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic commit;
    } ida_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan;
        logic hit;
    } ida_sts_t;

endpackage

>>> sv/ida_ctrl.sv
// controller state machine for the id slot allocator
module ida_ctrl
    import ida_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  ida_sts_t sts,
    output ida_cmd_t cmd
);

    ida_state_t state_reg;
    ida_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // state and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // keep walking bitmap words until the search hits
                if (sts.scan && !sts.hit)
                begin
                    cmd.step = 1'b1;
                end
                else if (!(rsp_valid_reg && rsp_stall))
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result held until taken
    assign rsp_valid_next = cmd.commit | (rsp_valid_reg & rsp_stall);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> sv/ida_datapath.sv
// slot bitmaps, handle store, counters and result register
module ida_datapath
    import ida_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int FREE_DEPTH  = FREE_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ida_cmd_t         cmd,
    output ida_sts_t         sts,
    input  ida_req_t         req,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output ida_rsp_t         rsp
);

    localparam int ID_W       = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int WORD_BITS  = (CAPACITY < WORD_BITS_MAX) ? (2 ** $clog2(CAPACITY))
                                                           : WORD_BITS_MAX;
    localparam int WORD_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int EXT_W      = (CNT_W > ID_FIELD_W) ? CNT_W : ID_FIELD_W;
    localparam int FREE_CNT_W = $clog2(FREE_DEPTH + 1);
    localparam int LIM_W      = (FREE_CNT_W > CFG_W) ? FREE_CNT_W : CFG_W;

    // bitmaps, one word per row, and the handle store
    logic [WORD_BITS-1:0]   occ_mem    [NUM_WORDS];
    logic [WORD_BITS-1:0]   mark_mem   [NUM_WORDS];
    logic [HANDLE_BITS-1:0] handle_mem [CAPACITY];

    logic [WORD_BITS-1:0]   rd_occ_reg;
    logic [WORD_BITS-1:0]   rd_mark_reg;
    logic [HANDLE_BITS-1:0] rd_handle_reg;

    ida_mode_t              mode_reg,       mode_next;
    logic [WIDX_W-1:0]      ptr_reg,        ptr_next;
    logic [ID_FIELD_W-1:0]  id_reg,         id_next;
    logic [HANDLE_BITS-1:0] handle_reg,     handle_next;
    logic [FREE_CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]       length_reg,     length_next;
    logic [CNT_W-1:0]       live_reg,       live_next;
    logic [WIDX_W-1:0]      hint_reg,       hint_next;
    logic [CFG_W-1:0]       max_free_reg,   max_free_next;
    ida_rsp_t               rsp_reg,        rsp_next;

    logic [WORD_BITS-1:0]   one_w;
    logic [WORD_BITS-1:0]   part_mask;
    logic [WORD_BITS-1:0]   len_mask;
    logic [CNT_W-1:0]       full_words;
    logic [CNT_W-1:0]       len_m1;
    logic [WORD_BITS-1:0]   occ_m;
    logic [WORD_BITS-1:0]   mark_m;
    logic [WORD_BITS-1:0]   empty_m;
    logic [WORD_W-1:0]      low_mark;
    logic [WORD_W-1:0]      high_empty;
    logic [WORD_W-1:0]      pick_bit;
    logic [WORD_BITS-1:0]   pick_oh;
    logic [ID_W-1:0]        pick_id;
    logic [LIM_W-1:0]       free_limit;
    logic                   in_range;
    logic                   occ_bit;
    logic                   mark_bit;

    logic                   bm_we;
    logic [WORD_BITS-1:0]   occ_wdata;
    logic [WORD_BITS-1:0]   mark_wdata;
    logic                   hdl_we;
    logic [ID_W-1:0]        hdl_raddr;

    // words are only valid below the high-water length
    assign one_w      = WORD_BITS'(1);
    assign full_words = length_reg >> WORD_W;
    assign part_mask  = (one_w << length_reg[WORD_W-1:0]) - one_w;
    assign len_m1     = length_reg - CNT_W'(1);

    always_comb
    begin
        if (CNT_W'(ptr_reg) < full_words)
            len_mask = '1;
        else if (CNT_W'(ptr_reg) == full_words)
            len_mask = part_mask;
        else
            len_mask = '0;
    end

    assign occ_m   = rd_occ_reg & len_mask;
    assign mark_m  = rd_mark_reg & len_mask;
    assign empty_m = ~rd_occ_reg & len_mask;

    // lowest marked bit and highest empty bit of the current word
    always_comb
    begin
        low_mark   = '0;
        high_empty = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (mark_m[i])
                low_mark = WORD_W'(i);
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (empty_m[j])
                high_empty = WORD_W'(j);
        end
    end

    // bit of the word the request works on
    always_comb
    begin
        case (mode_reg)
            MODE_FREE:   pick_bit = low_mark;
            MODE_EMPTY:  pick_bit = high_empty;
            MODE_APPEND: pick_bit = length_reg[WORD_W-1:0];
            default:     pick_bit = id_reg[WORD_W-1:0];
        endcase
    end

    assign pick_oh  = one_w << pick_bit;
    assign pick_id  = ID_W'({ptr_reg, pick_bit});
    assign occ_bit  = |(occ_m & pick_oh);
    assign mark_bit = |(mark_m & pick_oh);

    assign free_limit = (LIM_W'(max_free_reg) > LIM_W'(FREE_DEPTH)) ? LIM_W'(FREE_DEPTH)
                                                                     : LIM_W'(max_free_reg);

    assign in_range = EXT_W'(req.slot_id) < EXT_W'(length_reg);

    // search status
    always_comb
    begin
        sts.scan = (mode_reg == MODE_FREE) || (mode_reg == MODE_EMPTY);
        case (mode_reg)
            MODE_FREE:  sts.hit = |mark_m;
            MODE_EMPTY: sts.hit = |empty_m;
            default:    sts.hit = 1'b1;
        endcase
    end

    // request decode, search step and commit
    always_comb
    begin
        mode_next       = mode_reg;
        ptr_next        = ptr_reg;
        id_next         = id_reg;
        handle_next     = handle_reg;
        free_count_next = free_count_reg;
        length_next     = length_reg;
        live_next       = live_reg;
        hint_next       = hint_reg;
        rsp_next        = rsp_reg;
        bm_we           = 1'b0;
        occ_wdata       = occ_m;
        mark_wdata      = mark_m;
        hdl_we          = 1'b0;

        if (cmd.accept)
        begin
            id_next     = req.slot_id;
            handle_next = HANDLE_BITS'(req.object_handle);
            ptr_next    = WIDX_W'(EXT_W'(req.slot_id) >> WORD_W);
            case (req.func)
                FUNC_ADD:
                begin
                    if (free_count_reg != '0)
                    begin
                        mode_next = MODE_FREE;
                        ptr_next  = hint_reg;
                    end
                    else if (live_reg != length_reg)
                    begin
                        mode_next = MODE_EMPTY;
                        ptr_next  = WIDX_W'(len_m1 >> WORD_W);
                    end
                    else if (length_reg != CNT_W'(CAPACITY))
                    begin
                        mode_next = MODE_APPEND;
                        ptr_next  = WIDX_W'(full_words);
                    end
                    else
                    begin
                        mode_next = MODE_FULL;
                    end
                end
                FUNC_REMOVE: mode_next = in_range ? MODE_REMOVE : MODE_RANGE;
                FUNC_FIND:   mode_next = in_range ? MODE_FIND : MODE_RANGE;
                default:     mode_next = MODE_NOP;
            endcase
        end

        if (cmd.step)
        begin
            if (mode_reg == MODE_FREE)
                ptr_next = ptr_reg + WIDX_W'(1);
            else
                ptr_next = ptr_reg - WIDX_W'(1);
        end

        if (cmd.commit)
        begin
            rsp_next.result_id     = id_reg;
            rsp_next.result_handle = '0;
            rsp_next.found         = 1'b0;
            rsp_next.status        = STATUS_OK;
            case (mode_reg)
                MODE_FREE, MODE_EMPTY, MODE_APPEND:
                begin
                    bm_we     = 1'b1;
                    hdl_we    = 1'b1;
                    occ_wdata = occ_m | pick_oh;
                    if (!occ_bit)
                        live_next = live_reg + CNT_W'(1);
                    if (mode_reg == MODE_FREE)
                    begin
                        mark_wdata      = mark_m & ~pick_oh;
                        free_count_next = free_count_reg - FREE_CNT_W'(1);
                        hint_next       = ptr_reg;
                    end
                    if (mode_reg == MODE_APPEND)
                        length_next = length_reg + CNT_W'(1);
                    rsp_next.result_id = ID_FIELD_W'(pick_id);
                end
                MODE_FULL:
                begin
                    rsp_next.result_id = '0;
                    rsp_next.status    = STATUS_FULL;
                end
                MODE_REMOVE:
                begin
                    bm_we = 1'b1;
                    if (occ_bit)
                    begin
                        occ_wdata = occ_m & ~pick_oh;
                        live_next = live_reg - CNT_W'(1);
                    end
                    if (!mark_bit && (LIM_W'(free_count_reg) < free_limit))
                    begin
                        mark_wdata      = mark_m | pick_oh;
                        free_count_next = free_count_reg + FREE_CNT_W'(1);
                        if (ptr_reg < hint_reg)
                            hint_next = ptr_reg;
                    end
                end
                MODE_FIND:
                begin
                    rsp_next.found = occ_bit;
                    if (occ_bit)
                        rsp_next.result_handle = HANDLE_FIELD_W'(rd_handle_reg);
                end
                MODE_RANGE:
                begin
                    rsp_next.status = STATUS_RANGE;
                end
                default:
                begin
                    rsp_next.status = STATUS_OK;
                end
            endcase
            rsp_next.occupied_count = CNT_FIELD_W'(live_next);
        end
    end

    // configuration register
    assign max_free_next = cfg_wr_en ? cfg_wr_data : max_free_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NOP;
            ptr_reg        <= '0;
            free_count_reg <= '0;
            length_reg     <= '0;
            live_reg       <= '0;
            hint_reg       <= '0;
            max_free_reg   <= DEFAULT_MAX_FREE;
        end
        else
        begin
            mode_reg       <= mode_next;
            ptr_reg        <= ptr_next;
            free_count_reg <= free_count_next;
            length_reg     <= length_next;
            live_reg       <= live_next;
            hint_reg       <= hint_next;
            max_free_reg   <= max_free_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        handle_reg <= handle_next;
        rsp_reg    <= rsp_next;
    end

    // bitmap rows, read ahead at the next word pointer
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            occ_mem[ptr_reg]  <= occ_wdata;
            mark_mem[ptr_reg] <= mark_wdata;
        end
        rd_occ_reg  <= occ_mem[ptr_next];
        rd_mark_reg <= mark_mem[ptr_next];
    end

    // handle store
    assign hdl_raddr = cmd.accept ? ID_W'(req.slot_id) : ID_W'(id_reg);

    always_ff @(posedge clk)
    begin
        if (hdl_we)
            handle_mem[pick_id] <= handle_reg;
        rd_handle_reg <= handle_mem[hdl_raddr];
    end

    assign rsp = rsp_reg;

endmodule

>>> sv/id_slot_allocator.sv
// id slot allocator top level: controller and datapath
//
//  channel | valid     | stall     | payload      | config
//  --------+-----------+-----------+--------------+------------------------
//  request | req_valid | req_stall | req (struct) |
//  result  | rsp_valid | rsp_stall | rsp (struct) |
//  config  |           |           |              | cfg_wr_en, cfg_wr_data
//
// add, remove and find are accepted with the bitmap/handle read, then commit with one
// read-modify-write of a bitmap row of up to 32 bits; an add through the free set or the
// empty-slot search steps on once more for every further bitmap row it visits.
// no clearing pass after reset: rows above the high-water length read as empty.
// a stalled result holds; the next request is taken but commits only once it clears.
module id_slot_allocator
    import ida_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int FREE_DEPTH  = FREE_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ida_req_t         req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ida_rsp_t         rsp,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    ida_cmd_t cmd;
    ida_sts_t sts;

    // sequencing
    ida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot tables and counters
    ida_datapath #(
        .CAPACITY    (CAPACITY),
        .FREE_DEPTH  (FREE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp         (rsp)
    );

endmodule

>>> verif/tb_id_slot_allocator.sv
// self-checking testbench for the id slot allocator: directed and random requests against a predictor
module tb_id_slot_allocator;
    import ida_pkg::*;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int FREE_MAX    = FREE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 40;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;

    // opcode the block does not decode
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             req_valid   = 1'b0;
    logic             req_stall;
    ida_req_t         req         = '0;
    logic             rsp_valid;
    logic             rsp_stall   = 1'b0;
    ida_rsp_t         rsp;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    // requests waiting to be offered, results waiting to arrive
    ida_req_t req_pending [$];
    ida_rsp_t rsp_expected [$];

    // shadow of the slot table
    logic [HANDLE_FIELD_W-1:0] slot_handles [SLOTS];
    bit                        slot_used [SLOTS];
    bit                        slot_freed [SLOTS];
    int                        freed_count = 0;
    int                        high_water  = 0;
    int                        used_count  = 0;
    int                        free_cap    = DEFAULT_MAX_FREE;

    int mismatch_count = 0;
    int req_count      = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_mode     = 0;
    int mode_left      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    id_slot_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // apply one request to the shadow table and return the result it should give
    function automatic ida_rsp_t alloc_predict(input ida_req_t r);
        ida_rsp_t res;
        int       pick;
        bit       got;
        int       lim;
        res            = '0;
        res.result_id  = r.slot_id;
        pick           = 0;
        got            = 1'b0;
        lim            = (free_cap > FREE_MAX) ? FREE_MAX : free_cap;
        case (r.func)
            FUNC_ADD:
            begin
                // smallest recorded free id first
                if (freed_count > 0)
                begin
                    for (int i = 0; i < high_water && !got; i++)
                        if (slot_freed[i])
                        begin
                            pick = i;
                            got  = 1'b1;
                        end
                    if (got)
                    begin
                        slot_freed[pick] = 1'b0;
                        freed_count--;
                    end
                    else
                        freed_count = 0;
                end
                // then the highest empty slot below the length
                if (!got)
                    for (int i = high_water - 1; i >= 0 && !got; i--)
                        if (!slot_used[i])
                        begin
                            pick = i;
                            got  = 1'b1;
                        end
                // then append
                if (!got && high_water < SLOTS)
                begin
                    pick = high_water;
                    high_water++;
                    got = 1'b1;
                end
                if (got)
                begin
                    if (!slot_used[pick])
                        used_count++;
                    slot_used[pick]    = 1'b1;
                    slot_handles[pick] = r.object_handle;
                    res.result_id      = pick[ID_FIELD_W-1:0];
                end
                else
                begin
                    res.result_id = '0;
                    res.status    = STATUS_FULL;
                end
            end
            FUNC_REMOVE:
            begin
                if (int'(r.slot_id) < high_water)
                begin
                    if (slot_used[r.slot_id])
                    begin
                        slot_used[r.slot_id] = 1'b0;
                        used_count--;
                    end
                    if (!slot_freed[r.slot_id] && freed_count < lim)
                    begin
                        slot_freed[r.slot_id] = 1'b1;
                        freed_count++;
                    end
                end
                else
                    res.status = STATUS_RANGE;
            end
            FUNC_FIND:
            begin
                if (int'(r.slot_id) < high_water)
                begin
                    if (slot_used[r.slot_id])
                    begin
                        res.result_handle = slot_handles[r.slot_id];
                        res.found         = 1'b1;
                    end
                end
                else
                    res.status = STATUS_RANGE;
            end
            default:
                ;
        endcase
        res.occupied_count = used_count[CNT_FIELD_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic queue_req(input logic [FUNC_W-1:0] f, input int id,
                             input logic [HANDLE_FIELD_W-1:0] h);
        ida_req_t r;
        r.func          = f;
        r.slot_id       = id[ID_FIELD_W-1:0];
        r.object_handle = h;
        req_pending.insert(req_pending.size(), r);
    endtask

    // random mix, ids mostly near the current length
    task automatic queue_random(input int count, input int add_pct);
        int                roll;
        int                id;
        int                top;
        logic [FUNC_W-1:0] f;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                f = FUNC_ADD;
            else if (roll >= 98)
                f = FUNC_UNKNOWN;
            else if (roll[0])
                f = FUNC_REMOVE;
            else
                f = FUNC_FIND;
            top = (high_water + 1 > SLOTS - 1) ? SLOTS - 1 : high_water + 1;
            if ($urandom_range(0, 9) < 8)
                id = $urandom_range(0, top);
            else
                id = $urandom_range(0, SLOTS - 1);
            queue_req(f, id, $urandom);
        end
    endtask

    // wait until every request is in and every result is out
    task automatic wait_idle();
        while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_free_limit(input int v);
        wait_idle();
        @(posedge clk);
        cfg_wr_data <= v[CFG_W-1:0];
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        free_cap = v;
    endtask

    // request driver: bursts and gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
            begin
                rsp_expected.insert(rsp_expected.size(), alloc_predict(req));
                req_count++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (req_pending.size() > 0)
            begin
                req       <= req_pending.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result stall pattern, with one long hold-off while requests keep coming
    always @(posedge clk or negedge rst_n)
    begin : rsp_staller
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            mode_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (!hold_done && req_count >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 120);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= ~rsp_stall;
                endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin : rsp_monitor
        ida_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("result with no request outstanding: result_id %0d", rsp.result_id);
                mismatch_count++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                check_field("result_id", 32'(want.result_id), 32'(rsp.result_id));
                check_field("result_handle", 32'(want.result_handle),
                            32'(rsp.result_handle));
                check_field("found", 32'(want.found), 32'(rsp.found));
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("occupied_count", 32'(want.occupied_count),
                            32'(rsp.occupied_count));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: out of range find and remove, undecoded opcode
        queue_req(FUNC_FIND, 0, 32'h0);
        queue_req(FUNC_REMOVE, 0, 32'h0);
        queue_req(FUNC_UNKNOWN, SLOTS - 1, 32'hFFFF_FFFF);
        // appends with extreme handles
        queue_req(FUNC_ADD, SLOTS - 1, 32'h0);
        queue_req(FUNC_ADD, 0, 32'hFFFF_FFFF);
        queue_req(FUNC_ADD, 0, 32'hA5A5_5A5A);
        queue_req(FUNC_FIND, 1, 32'h0);
        queue_req(FUNC_FIND, 0, 32'hFFFF_FFFF);
        // remove, remove again on an empty slot already free, find on empty slot
        queue_req(FUNC_REMOVE, 1, 32'h0);
        queue_req(FUNC_REMOVE, 1, 32'h0);
        queue_req(FUNC_FIND, 1, 32'h0);
        // add reuses the freed id
        queue_req(FUNC_ADD, 0, 32'h1234_5678);
        queue_req(FUNC_FIND, SLOTS - 1, 32'h0);
        queue_req(FUNC_REMOVE, 3, 32'h0);
        queue_req(FUNC_UNKNOWN, 0, 32'h0);
        queue_req(FUNC_REMOVE, 0, 32'h0);

        // lowered limit: the id already recorded stays, new ones are dropped
        write_free_limit(0);
        queue_req(FUNC_REMOVE, 2, 32'h0);
        queue_req(FUNC_ADD, 0, 32'h0F0F_0F0F);
        queue_req(FUNC_ADD, 0, 32'hF0F0_F0F0);
        queue_req(FUNC_FIND, 2, 32'h0);
        queue_req(FUNC_REMOVE, 1, 32'h0);
        queue_req(FUNC_ADD, 0, 32'h8000_0001);

        // limit above the free set depth
        write_free_limit(255);
        queue_random(150, 55);

        // free set of one
        write_free_limit(1);
        queue_random(100, 50);

        // fill the table; once the free set drains, reuse is through the empty-slot search only
        write_free_limit(0);
        while (high_water < SLOTS)
        begin
            queue_random(48, 95);
            wait_idle();
        end
        repeat (SLOTS - used_count + 6) queue_req(FUNC_ADD, 0, $urandom);
        queue_req(FUNC_FIND, SLOTS - 1, 32'h0);

        // churn on a full-length table
        write_free_limit(FREE_MAX);
        queue_random(80, 40);
        write_free_limit($urandom_range(2, FREE_MAX - 1));
        queue_random(60, 50);
        write_free_limit(DEFAULT_MAX_FREE);
        queue_random(60, 50);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/ida_pkg.sv
sv/ida_ctrl.sv
sv/ida_datapath.sv
sv/id_slot_allocator.sv
verif/tb_id_slot_allocator.sv
